/* hw/rtl/markup_tag_to_html_stream_defines.svh */
// ----------------------------------------------------------------------------
// Markup tag to HTML stream assertion macros
// Concurrent assertion helpers used by the emitter RTL module.
// ----------------------------------------------------------------------------
`ifndef MARKUP_TAG_TO_HTML_STREAM_DEFINES_SVH
`define MARKUP_TAG_TO_HTML_STREAM_DEFINES_SVH
`ifndef SYNTHESIS
`define MT_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define MT_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define MT_ASSERT_IMP(label, clk, rst, a, c)
`define MT_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

/* hw/rtl/mth_pkg.sv */
// ----------------------------------------------------------------------------
// Markup tag to HTML package
// Command codes passed from the front end to the emitter, and string table.
// ----------------------------------------------------------------------------
package mth_pkg;

   // emitter operations
   typedef enum logic [2:0] {
      OP_STR,
      OP_TAG,
      OP_DIG,
      OP_BYTE
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [5:0] str_id;
      logic [3:0] start;
      logic [7:0] value;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic [7:0][7:0] buf_q;
      logic [3:0]      len;
   } tag_type;

   localparam logic [5:0] S_WG_A = 6'd0, S_QGT = 6'd1, S_WG_C = 6'd2,
      S_WT_A = 6'd3, S_SPQ = 6'd4, S_WT_C = 6'd5, S_WP_A = 6'd6, S_WP_C = 6'd7,
      S_I = 6'd8, S_FN_I = 6'd9, S_FONT = 6'd10, S_RFE = 6'd11, S_NI = 6'd12,
      S_B = 6'd13, S_NB = 6'd14, S_RED = 6'd15, S_NFONT = 6'd16, S_U = 6'd17,
      S_NU = 6'd18, S_CITE = 6'd19, S_NCITE = 6'd20, S_SUP = 6'd21,
      S_NSUP = 6'd22, S_SUB = 6'd23, S_NSUB = 6'd24, S_FACE = 6'd25,
      S_FACE_E = 6'd26, S_LFONT = 6'd27, S_BRS = 6'd28, S_BR = 6'd29,
      S_DIVR = 6'd30, S_DIVC = 6'd31, S_NCENT = 6'd32, S_NDIV = 6'd33,
      S_BIG = 6'd34, S_NBIG = 6'd35, S_NONE = 6'd63;

   function automatic string str_text(logic [5:0] id);
      unique case (id)
         S_WG_A:   return " <small><em>&lt;<a href=\"#";
         S_QGT:    return "\">";
         S_WG_C:   return "</a>&gt;</em></small> ";
         S_WT_A:   return " <small><em>(<a href=\"#";
         S_SPQ:    return " \">";
         S_WT_C:   return "</a>)</em></small> ";
         S_WP_A:   return " <small><em>(";
         S_WP_C:   return ")</em></small> ";
         S_I:      return "<I>";
         S_FN_I:   return "</I> ";
         S_FONT:   return "<FONT COLOR=\"#800000\"> <SMALL>(";
         S_RFE:    return ")</SMALL> </FONT>";
         S_NI:     return "</I>";
         S_B:      return "<B>";
         S_NB:     return "</B>";
         S_RED:    return "<FONT COLOR=#FF0000>";
         S_NFONT:  return "</FONT>";
         S_U:      return "<U>";
         S_NU:     return "</U>";
         S_CITE:   return "<CITE>";
         S_NCITE:  return "</CITE>";
         S_SUP:    return "<SUP>";
         S_NSUP:   return "</SUP>";
         S_SUB:    return "<SUB>";
         S_NSUB:   return "</SUB>";
         S_FACE:   return "<font face=\"";
         S_FACE_E: return "\">";
         S_LFONT:  return "</font>";
         S_BRS:    return "<BR> ";
         S_BR:     return "<BR>";
         S_DIVR:   return "<DIV ALIGN=\"RIGHT\">";
         S_DIVC:   return "<DIV ALIGN=\"CENTER\">";
         S_NCENT:  return "</CENTER>";
         S_NDIV:   return "</DIV>";
         S_BIG:    return "<big>";
         S_NBIG:   return "</big>";
         default:  return "";
      endcase
   endfunction

   function automatic logic [5:0] str_len(logic [5:0] id);
      string s;
      s = str_text(id);
      return 6'(s.len());
   endfunction

   function automatic logic [7:0] str_char(logic [5:0] id, logic [4:0] pos);
      string s;
      s = str_text(id);
      return (int'(pos) < s.len()) ? 8'(s[pos]) : 8'd0;
   endfunction

endpackage

/* hw/rtl/mth_front.sv */
// ----------------------------------------------------------------------------
// Markup tag front end
// Collects tag bytes, decodes closes into emitter command sequences and passes plain bytes on as byte commands.
// ----------------------------------------------------------------------------
module mth_front #(
   parameter int TagMax = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  logic [7:0]           in_byte,
   output logic                 cmd_valid,
   input  logic                 cmd_stall,
   output mth_pkg::cmd_type     cmd,
   output mth_pkg::tag_type     tag
);

   typedef enum logic [1:0] {ST_IDLE, ST_SEQ} state_type;

   state_type        state_ff, state_in;
   logic             in_tag_ff, in_tag_in;
   logic [7:0][7:0]  buf_ff, buf_in;
   logic [3:0]       len_ff, len_in;
   logic             fn_ff, fn_in, rj_ff, rj_in, ce_ff, ce_in;
   mth_pkg::cmd_type seq_ff [6], seq_in [6];
   logic [2:0]       cnt_ff, cnt_in, pos_ff, pos_in;
   logic [7:0]       ch;
   logic             acc;

   assign ch  = (in_byte == 8'd10) ? 8'd32 : in_byte;
   assign acc = in_valid && !in_stall;
   assign tag = '{buf_q: buf_ff, len: len_ff};

   function automatic logic [7:0] tch(logic [7:0][7:0] b, logic [3:0] l, int i);
      return (i < int'(l)) ? b[i] : 8'd0;
   endfunction

   function automatic logic [7:0] atoi(logic [7:0][7:0] b, logic [3:0] l);
      logic [15:0] v;
      logic        neg, skip, dig;
      logic [7:0]  c;
      v = '0; neg = 1'b0; skip = 1'b1; dig = 1'b1;
      for (int i = 2; i < 8; i++) begin
         c = tch(b, l, i);
         if (skip && ((c >= 8'd9 && c <= 8'd13) || c == 8'd32)) begin
         end else if (skip && (c == "-" || c == "+")) begin
            neg = (c == "-"); skip = 1'b0;
         end else begin
            skip = 1'b0;
            if (dig && c >= "0" && c <= "9") v = 16'(v * 10 + 16'(c - "0"));
            else dig = 1'b0;
         end
      end
      if (neg) v = 16'(0 - v);
      return v[7:0];
   endfunction

   function automatic mth_pkg::cmd_type mk(mth_pkg::op_type o, logic [5:0] s,
                                           logic [3:0] st, logic [7:0] v);
      return '{op: o, str_id: s, start: st, value: v, last: 1'b0};
   endfunction

   always_comb begin
      logic [7:0] a, b, c;
      state_in = state_ff; in_tag_in = in_tag_ff; buf_in = buf_ff; len_in = len_ff;
      fn_in = fn_ff; rj_in = rj_ff; ce_in = ce_ff; seq_in = seq_ff;
      cnt_in = cnt_ff; pos_in = pos_ff;
      a = tch(buf_ff, len_ff, 0); b = tch(buf_ff, len_ff, 1);
      c = tch(buf_ff, len_ff, 2);
      if (state_ff == ST_SEQ && !cmd_stall) begin
         pos_in = 3'(pos_ff + 3'd1);
         if (pos_in == cnt_ff) state_in = ST_IDLE;
      end
      if (acc && ch != 8'd0) begin
         for (int k = 0; k < 6; k++)
            seq_in[k] = mk(mth_pkg::OP_STR, mth_pkg::S_NONE, 4'd0, 8'd0);
         cnt_in = 3'd0; pos_in = 3'd0;
         if (ch == "<") begin
            in_tag_in = 1'b1; len_in = '0; buf_in = '0;
         end else if (ch == ">") begin
            in_tag_in = 1'b0;
            priority if (a == "W" && (b == "G" || b == "H")) begin
               seq_in[0] = mk(mth_pkg::OP_STR, mth_pkg::S_WG_A, 4'd0, 8'd0);
               seq_in[1] = mk(mth_pkg::OP_TAG, mth_pkg::S_NONE, 4'd1, 8'd0);
               seq_in[2] = mk(mth_pkg::OP_STR, mth_pkg::S_QGT, 4'd0, 8'd0);
               seq_in[3] = mk(mth_pkg::OP_DIG, mth_pkg::S_NONE, 4'd2, 8'd0);
               seq_in[4] = mk(mth_pkg::OP_STR, mth_pkg::S_WG_C, 4'd0, 8'd0);
               cnt_in = 3'd5;
            end else if (a == "W" && b == "T" && (c == "G" || c == "H")) begin
               seq_in[0] = mk(mth_pkg::OP_STR, mth_pkg::S_WT_A, 4'd0, 8'd0);
               seq_in[1] = mk(mth_pkg::OP_TAG, mth_pkg::S_NONE, 4'd1, 8'd0);
               seq_in[2] = mk(mth_pkg::OP_STR, mth_pkg::S_SPQ, 4'd0, 8'd0);
               seq_in[3] = mk(mth_pkg::OP_DIG, mth_pkg::S_NONE, 4'd2, 8'd0);
               seq_in[4] = mk(mth_pkg::OP_STR, mth_pkg::S_WT_C, 4'd0, 8'd0);
               cnt_in = 3'd5;
            end else if (a == "W" && b == "T") begin
               seq_in[0] = mk(mth_pkg::OP_STR, mth_pkg::S_WP_A, 4'd0, 8'd0);
               seq_in[1] = mk(mth_pkg::OP_TAG, mth_pkg::S_NONE, 4'd2, 8'd0);
               seq_in[2] = mk(mth_pkg::OP_STR, mth_pkg::S_WP_C, 4'd0, 8'd0);
               cnt_in = 3'd3;
            end else if (a == "R" && b == "B") begin
               seq_in[0] = mk(mth_pkg::OP_STR, mth_pkg::S_I, 4'd0, 8'd0);
               cnt_in = 3'd1; fn_in = 1'b1;
            end else if (a == "R" && b == "F") begin
               if (fn_ff) begin
                  seq_in[0] = mk(mth_pkg::OP_STR, mth_pkg::S_FN_I, 4'd0, 8'd0);
                  seq_in[1] = mk(mth_pkg::OP_STR, mth_pkg::S_FONT, 4'd0, 8'd0);
                  cnt_in = 3'd2;
               end else begin
                  seq_in[0] = mk(mth_pkg::OP_STR, mth_pkg::S_FONT, 4'd0, 8'd0);
                  cnt_in = 3'd1;
               end
            end else if (a == "R" && b == "f") begin
               seq_in[0] = mk(mth_pkg::OP_STR, mth_pkg::S_RFE, 4'd0, 8'd0);
               cnt_in = 3'd1; fn_in = 1'b0;
            end else if (a == "F" && b == "N") begin
               seq_in[0] = mk(mth_pkg::OP_STR, mth_pkg::S_FACE, 4'd0, 8'd0);
               seq_in[1] = mk(mth_pkg::OP_TAG, mth_pkg::S_NONE, 4'd2, 8'd0);
               seq_in[2] = mk(mth_pkg::OP_STR, mth_pkg::S_FACE_E, 4'd0, 8'd0);
               cnt_in = 3'd3;
            end else if (a == "F") begin
               seq_in[0] = mk(mth_pkg::OP_STR, mth_pkg::S_NONE, 4'd0, 8'd0);
               cnt_in = 3'd1;
               unique case (b)
                  "I": seq_in[0].str_id = mth_pkg::S_I;
                  "i": seq_in[0].str_id = mth_pkg::S_NI;
                  "B": seq_in[0].str_id = mth_pkg::S_B;
                  "b": seq_in[0].str_id = mth_pkg::S_NB;
                  "R": seq_in[0].str_id = mth_pkg::S_RED;
                  "r": seq_in[0].str_id = mth_pkg::S_NFONT;
                  "U": seq_in[0].str_id = mth_pkg::S_U;
                  "u": seq_in[0].str_id = mth_pkg::S_NU;
                  "O": seq_in[0].str_id = mth_pkg::S_CITE;
                  "o": seq_in[0].str_id = mth_pkg::S_NCITE;
                  "S": seq_in[0].str_id = mth_pkg::S_SUP;
                  "s": seq_in[0].str_id = mth_pkg::S_NSUP;
                  "V": seq_in[0].str_id = mth_pkg::S_SUB;
                  "v": seq_in[0].str_id = mth_pkg::S_NSUB;
                  "n": seq_in[0].str_id = mth_pkg::S_LFONT;
                  default: cnt_in = 3'd0;
               endcase
            end else if (a == "C" && b == "A") begin
               seq_in[0] = mk(mth_pkg::OP_BYTE, mth_pkg::S_NONE, 4'd0,
                              atoi(buf_ff, len_ff));
               cnt_in = 3'd1;
            end else if (a == "C" && (b == "L" || b == "M")) begin
               seq_in[0] = mk(mth_pkg::OP_STR, (b == "L") ? mth_pkg::S_BRS : mth_pkg::S_BR,
                              4'd0, 8'd0);
               cnt_in = 3'd1;
            end else if (a == "J" && (b == "R" || b == "C")) begin
               seq_in[0] = mk(mth_pkg::OP_STR, (b == "R") ? mth_pkg::S_DIVR : mth_pkg::S_DIVC,
                              4'd0, 8'd0);
               cnt_in = 3'd1;
               if (b == "R") rj_in = 1'b1; else ce_in = 1'b1;
            end else if (a == "J" && b == "L") begin
               if (ce_ff && rj_ff) begin
                  seq_in[0] = mk(mth_pkg::OP_STR, mth_pkg::S_NCENT, 4'd0, 8'd0);
                  seq_in[1] = mk(mth_pkg::OP_STR, mth_pkg::S_NDIV, 4'd0, 8'd0);
                  cnt_in = 3'd2;
               end else if (ce_ff || rj_ff) begin
                  seq_in[0] = mk(mth_pkg::OP_STR, ce_ff ? mth_pkg::S_NCENT : mth_pkg::S_NDIV,
                                 4'd0, 8'd0);
                  cnt_in = 3'd1;
               end
               ce_in = 1'b0; rj_in = 1'b0;
            end else if ((a == "T" && (b == "T" || b == "t"))
                         || (a == "P" && (b == "P" || b == "p"))) begin
               seq_in[0] = mk(mth_pkg::OP_STR, mth_pkg::S_NONE, 4'd0, 8'd0);
               cnt_in = 3'd1;
               unique case (b)
                  "T": seq_in[0].str_id = mth_pkg::S_BIG;
                  "t": seq_in[0].str_id = mth_pkg::S_NBIG;
                  "P": seq_in[0].str_id = mth_pkg::S_CITE;
                  default: seq_in[0].str_id = mth_pkg::S_NCITE;
               endcase
            end else begin
               // unknown code: nothing to emit
            end
         end else if (in_tag_ff) begin
            if (int'(len_ff) < TagMax && len_ff < 4'd8) begin
               buf_in[len_ff[2:0]] = ch;
               len_in = 4'(len_ff + 4'd1);
            end
         end else begin
            seq_in[0] = mk(mth_pkg::OP_BYTE, mth_pkg::S_NONE, 4'd0, ch);
            cnt_in = 3'd1;
         end
         if (cnt_in != 3'd0) begin
            seq_in[cnt_in - 3'd1].last = 1'b1;
            state_in = ST_SEQ;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; in_tag_ff <= 1'b0; buf_ff <= '0; len_ff <= '0;
         fn_ff <= 1'b0; rj_ff <= 1'b0; ce_ff <= 1'b0; cnt_ff <= '0; pos_ff <= '0;
      end else begin
         state_ff <= state_in; in_tag_ff <= in_tag_in; buf_ff <= buf_in;
         len_ff <= len_in; fn_ff <= fn_in; rj_ff <= rj_in; ce_ff <= ce_in;
         cnt_ff <= cnt_in; pos_ff <= pos_in;
      end
      seq_ff <= seq_in;
   end

   assign in_stall  = (state_ff == ST_SEQ);
   assign cmd_valid = (state_ff == ST_SEQ);
   assign cmd       = seq_ff[pos_ff];

endmodule

/* hw/rtl/mth_back.sv */
// ----------------------------------------------------------------------------
// Markup tag emitter
// Expands commands into output bytes: strings, tag copies, digits, literals.
// ----------------------------------------------------------------------------
`include "markup_tag_to_html_stream_defines.svh"
module mth_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_stall,
   input  mth_pkg::cmd_type cmd,
   input  mth_pkg::tag_type tag,
   output logic             out_valid,
   input  logic             out_stall,
   output logic [7:0]       out_byte,
   output logic             out_last
);

   logic             busy_ff, busy_in;
   mth_pkg::cmd_type cur_ff, cur_in;
   logic [4:0]       idx_ff, idx_in;
   logic             v_ff, v_in, l_ff, l_in;
   logic [7:0]       b_ff, b_in;
   logic [7:0]       ch;
   logic             elig, done, free;
   logic [4:0]       ni;
   logic [5:0]       slen;
   logic [3:0]       tpos;

   assign free = !v_ff || !out_stall;
   assign slen = mth_pkg::str_len(cur_ff.str_id);
   assign tpos = 4'(cur_ff.start + idx_ff[3:0]);

   always_comb begin
      ch = 8'd0; elig = 1'b0; done = 1'b1;
      unique case (cur_ff.op)
         mth_pkg::OP_STR: begin
            ch = mth_pkg::str_char(cur_ff.str_id, idx_ff);
            elig = ({1'b0, idx_ff} < slen);
            done = ({1'b0, idx_ff} + 6'd1 >= slen);
         end
         mth_pkg::OP_TAG, mth_pkg::OP_DIG: begin
            ch = (tpos < tag.len) ? tag.buf_q[tpos[2:0]] : 8'd0;
            elig = (tpos < tag.len) &&
                   (cur_ff.op == mth_pkg::OP_TAG || (ch >= "0" && ch <= "9"));
            done = (4'(tpos + 4'd1) >= tag.len) || tpos == 4'd15;
         end
         default: begin
            ch = cur_ff.value; elig = 1'b1; done = 1'b1;
         end
      endcase
   end

   assign ni = 5'(idx_ff + 5'd1);

   always_comb begin
      busy_in = busy_ff; cur_in = cur_ff; idx_in = idx_ff;
      v_in = v_ff && out_stall; l_in = l_ff; b_in = b_ff;
      if (busy_ff && free) begin
         if (elig) begin
            v_in = 1'b1; b_in = ch; l_in = cur_ff.last && done;
         end else if (cur_ff.last && done && v_ff) begin
            // nothing left to show; previous byte was already handed off
         end
         idx_in = ni;
         if (done) busy_in = 1'b0;
      end
      if (!busy_in && cmd_valid && !cmd_stall) begin
         busy_in = 1'b1; cur_in = cmd; idx_in = '0;
      end
   end

   assign cmd_stall = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; v_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; v_ff <= v_in;
      end
      cur_ff <= cur_in; idx_ff <= idx_in; l_ff <= l_in; b_ff <= b_in;
   end

   assign out_valid = v_ff;
   assign out_byte  = b_ff;
   assign out_last  = l_ff;

   `MT_ASSERT_NXT(a_hold, clock, reset, v_ff && out_stall, v_ff && $stable(b_ff))
   `MT_ASSERT_IMP(a_noacc, clock, reset, busy_ff, cmd_stall)
   `MT_ASSERT_NXT(a_load, clock, reset, !busy_ff && cmd_valid, busy_ff)

endmodule

/* hw/rtl/markup_tag_to_html_stream.sv */
// ----------------------------------------------------------------------------
// Markup tag to HTML stream
// Converts a markup byte stream into HTML text bytes.
// ----------------------------------------------------------------------------
// Input channel req_valid/req_stall/req_in_byte takes one text byte per item.
// Result channel rsp_valid/rsp_stall carries rsp_out_byte and rsp_last_of_run,
// which marks the final byte caused by one input item.
// A plain byte is registered as a command in the front end, then loaded into
// the emitter's command register and registered as a result byte; input
// stalls while the front end hands its command list (up to five commands) to
// the emitter. The emitter walks each string or tag copy one position a cycle
// while the receiver does not stall; positions that give no byte (non-digits)
// are stepped over the same way.
// Bytes inside a tag and closes of unknown tags yield no result.
// Reset clears the tag buffer, the open flags and all valid state.
// When the receiver stalls the result register holds and the emitter waits.
// ----------------------------------------------------------------------------
module markup_tag_to_html_stream #(
   parameter int TAG_MAX = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);

   logic             cmd_valid, cmd_stall;
   mth_pkg::cmd_type cmd;
   mth_pkg::tag_type tag;

   mth_front #(.TagMax(TAG_MAX)) u_front (
      .clock, .reset, .in_valid(req_valid), .in_stall(req_stall),
      .in_byte(req_in_byte), .cmd_valid, .cmd_stall, .cmd, .tag
   );

   mth_back u_back (
      .clock, .reset, .cmd_valid, .cmd_stall, .cmd, .tag,
      .out_valid(rsp_valid), .out_stall(rsp_stall),
      .out_byte(rsp_out_byte), .out_last(rsp_last_of_run)
   );

endmodule

/* tb/sv/tb_markup_tag_to_html_stream.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Markup tag to HTML stream testbench
// Feeds markup text (plain bytes, well-formed tags and noise) through the
// block and checks every emitted HTML byte and its end-of-run flag against
// a behavioral converter kept in step with the accepted input items.
// ----------------------------------------------------------------------------
module tb_markup_tag_to_html_stream;

   localparam int TAG_MAX = 8;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } html_byte_t;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_in_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_run;

   markup_tag_to_html_stream #(.TAG_MAX(TAG_MAX)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_in_byte(req_in_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_byte(rsp_out_byte),
      .rsp_last_of_run(rsp_last_of_run)
   );

   // converter state
   logic            tag_open;
   logic [7:0][7:0] tag_text;
   logic [3:0]      tag_count;
   logic            fn_open, rj_open, ctr_open;

   logic [7:0]  text_q[$];
   html_byte_t  html_q[$];
   byte unsigned run_q[$];

   int send_idle_pct, recv_stall_pct;
   int hold_off;
   bit stim_done;
   bit req_taken;
   int errors, cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [7:0] tag_at(int i);
      if (i >= tag_count || i >= 8) return 8'd0;
      return tag_text[i];
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic void put_str(string s);
      for (int i = 0; i < s.len(); i++) run_q.push_back(s[i]);
   endfunction

   function automatic void put_tag(int start);
      for (int i = start; i < tag_count; i++) run_q.push_back(tag_at(i));
   endfunction

   function automatic void put_digits(int start);
      for (int i = start; i < tag_count; i++)
         if (is_digit(tag_at(i))) run_q.push_back(tag_at(i));
   endfunction

   function automatic logic [7:0] ca_value();
      int i;
      logic [15:0] v;
      bit neg;
      i = 2;
      v = '0;
      neg = 0;
      while ((tag_at(i) >= 9 && tag_at(i) <= 13) || tag_at(i) == 32) i++;
      if (tag_at(i) == "-") begin
         neg = 1;
         i++;
      end else if (tag_at(i) == "+") begin
         i++;
      end
      while (is_digit(tag_at(i))) begin
         v = v * 16'd10 + 16'(tag_at(i) - "0");
         i++;
      end
      if (neg) v = -v;
      return v[7:0];
   endfunction

   function automatic void decode_close();
      logic [7:0] a, b, c;
      a = tag_at(0);
      b = tag_at(1);
      c = tag_at(2);
      case (a)
         "W": begin
            if (b == "G" || b == "H") begin
               put_str(" <small><em>&lt;<a href=\"#");
               put_tag(1);
               put_str("\">");
               put_digits(2);
               put_str("</a>&gt;</em></small> ");
            end else if (b == "T") begin
               if (c == "G" || c == "H") begin
                  put_str(" <small><em>(<a href=\"#");
                  put_tag(1);
                  put_str(" \">");
                  put_digits(2);
                  put_str("</a>)</em></small> ");
               end else begin
                  put_str(" <small><em>(");
                  put_tag(2);
                  put_str(")</em></small> ");
               end
            end
         end
         "R": begin
            if (b == "B") begin
               put_str("<I>");
               fn_open = 1;
            end else if (b == "F") begin
               if (fn_open) put_str("</I> ");
               put_str("<FONT COLOR=\"#800000\"> <SMALL>(");
            end else if (b == "f") begin
               put_str(")</SMALL> </FONT>");
               fn_open = 0;
            end
         end
         "F": begin
            case (b)
               "I": put_str("<I>");
               "i": put_str("</I>");
               "B": put_str("<B>");
               "b": put_str("</B>");
               "R": put_str("<FONT COLOR=#FF0000>");
               "r": put_str("</FONT>");
               "U": put_str("<U>");
               "u": put_str("</U>");
               "O": put_str("<CITE>");
               "o": put_str("</CITE>");
               "S": put_str("<SUP>");
               "s": put_str("</SUP>");
               "V": put_str("<SUB>");
               "v": put_str("</SUB>");
               "N": begin
                  put_str("<font face=\"");
                  put_tag(2);
                  put_str("\">");
               end
               "n": put_str("</font>");
               default: ;
            endcase
         end
         "C": begin
            if (b == "A") run_q.push_back(ca_value());
            else if (b == "L") put_str("<BR> ");
            else if (b == "M") put_str("<BR>");
         end
         "J": begin
            if (b == "R") begin
               put_str("<DIV ALIGN=\"RIGHT\">");
               rj_open = 1;
            end else if (b == "C") begin
               put_str("<DIV ALIGN=\"CENTER\">");
               ctr_open = 1;
            end else if (b == "L") begin
               if (ctr_open) begin
                  put_str("</CENTER>");
                  ctr_open = 0;
               end
               if (rj_open) begin
                  put_str("</DIV>");
                  rj_open = 0;
               end
            end
         end
         "T": begin
            if (b == "T") put_str("<big>");
            else if (b == "t") put_str("</big>");
         end
         "P": begin
            if (b == "P") put_str("<CITE>");
            else if (b == "p") put_str("</CITE>");
         end
         default: ;
      endcase
   endfunction

   function automatic void convert_byte(logic [7:0] ch);
      run_q.delete();
      if (ch == 8'd0) return;
      if (ch == 8'd10) ch = " ";
      if (ch == "<") begin
         tag_open = 1;
         tag_count = 0;
         tag_text = '0;
      end else if (ch == ">") begin
         tag_open = 0;
         decode_close();
      end else if (tag_open) begin
         if (tag_count < TAG_MAX) begin
            tag_text[tag_count[2:0]] = ch;
            tag_count++;
         end
      end else begin
         run_q.push_back(ch);
      end
      for (int k = 0; k < run_q.size() && k < 64; k++)
         html_q.push_back({run_q[k], 1'(k == run_q.size() - 1)});
   endfunction

   task automatic push_str(string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   task automatic push_random_tag();
      string codes[$];
      int n;
      codes = '{"WG", "WH", "WT", "WTG", "WTH", "RB", "RF", "Rf", "FI", "Fi", "FB",
                "Fb", "FR", "Fr", "FU", "Fu", "FO", "Fo", "FS", "Fs", "FV", "Fv",
                "FN", "Fn", "CA", "CL", "CM", "CG", "CT", "JR", "JC", "JL", "TT",
                "Tt", "PP", "Pp", "XY"};
      text_q.push_back("<");
      push_str(codes[$urandom_range(codes.size() - 1)]);
      n = $urandom_range(7);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0: text_q.push_back(8'($urandom_range("0", "9")));
            1: text_q.push_back(8'($urandom_range(1, 255)));
            2: text_q.push_back(8'($urandom_range("a", "z")));
            default: text_q.push_back(($urandom_range(1)) ? 8'd10 : " ");
         endcase
      end
      text_q.push_back(">");
   endtask

   task automatic wait_drained();
      while (text_q.size() != 0 || html_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_in_byte <= text_q[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_stall <= 1'b1;
         hold_off <= hold_off - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
      if (!reset) begin
         cycles <= cycles + 1;
         if (req_valid && !req_stall) begin
            convert_byte(req_in_byte);
            void'(text_q.pop_front());
         end
         if (rsp_valid && !rsp_stall) begin
            if (html_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected result byte %h last %b", rsp_out_byte,
                           rsp_last_of_run);
            end else begin
               html_byte_t e;
               e = html_q.pop_front();
               if (e.out_byte !== rsp_out_byte || e.last !== rsp_last_of_run) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected %h/%b got %h/%b", e.out_byte,
                              e.last, rsp_out_byte, rsp_last_of_run);
               end
            end
         end
         if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_byte = 8'd0;
      req_taken = 1'b0;
      rsp_stall = 1'b0;
      hold_off = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      errors = 0;
      cycles = 0;
      stim_done = 0;
      tag_open = 0;
      tag_text = '0;
      tag_count = 0;
      fn_open = 0;
      rj_open = 0;
      ctr_open = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed
      text_q.push_back(">");
      text_q.push_back(8'd1);
      text_q.push_back(8'd255);
      text_q.push_back(8'd10);
      text_q.push_back(8'd0);
      push_str("A<RB>x<RF>");
      push_str("<Rf><RF><WG1234>>");
      push_str("<WTH12ab><WTxyz><WT><FNabcdefgh><CA -300><CA+65><CA\t\n-1x>");
      push_str("<JR><JC><JL><JL><CG><CT><ZZ>");
      push_str("<FI><Fi><FB><Fb><FR><Fr><FU><Fu><FO><Fo><FS><Fs><FV><Fv><Fn>");
      push_str("<CL><CM><TT><Tt><PP><Pp><WH99999999999>");
      text_q.push_back(8'hAA);
      text_q.push_back(8'h55);
      wait_drained();

      // long receiver hold-off while input keeps coming
      for (int i = 0; i < 2; i++) push_random_tag();
      hold_off = 300;
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 57 : 17) : 0;
         recv_stall_pct = (ph == 2) ? 57 : ((ph == 3) ? 17 : 0);
         for (int n = 0; n < 6; ) begin
            if ($urandom_range(9) < 4) begin
               push_random_tag();
               n += 4;
            end else if ($urandom_range(9) == 0) begin
               text_q.push_back(($urandom_range(1)) ? ">" : "<");
               n++;
            end else begin
               text_q.push_back(8'($urandom_range(1, 255)));
               n++;
            end
         end
         wait_drained();
      end
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
